// ----- rtl/rvie_pkg.sv -----
// shared types and constants of the register vm instruction executor
package rvie_pkg;

   localparam int unsigned DATA_W  = 16;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned KIND_W  = 4;

   typedef logic [DATA_W-1:0]  word_type;
   typedef logic [INDEX_W-1:0] index_type;

   // instruction kinds; codes above sysc execute as nop
   typedef enum logic [KIND_W-1:0] {
      KIND_NOP     = 4'd0,
      KIND_JMP     = 4'd1,
      KIND_JE      = 4'd2,
      KIND_MOV_REG = 4'd3,
      KIND_MOV_IMM = 4'd4,
      KIND_ADD_REG = 4'd5,
      KIND_ADD_IMM = 4'd6,
      KIND_CMP_REG = 4'd7,
      KIND_CMP_IMM = 4'd8,
      KIND_SYSC    = 4'd9
   } kind_type;

   // instruction lengths
   localparam word_type LEN_SHORT = 16'd1;
   localparam word_type LEN_REG   = 16'd3;
   localparam word_type LEN_IMM   = 16'd4;

endpackage

// ----- rtl/rvie_req_if.sv -----
// request channel carrying one decoded instruction
interface rvie_req_if;
   logic                                valid;
   logic                                ready;
   logic [rvie_pkg::KIND_W-1:0]         kind;
   rvie_pkg::index_type                 first_reg;
   rvie_pkg::index_type                 second_reg;
   rvie_pkg::word_type                  immediate;

   modport source (output valid, kind, first_reg, second_reg, immediate, input ready);
   modport sink   (input valid, kind, first_reg, second_reg, immediate, output ready);
endinterface

// ----- rtl/rvie_rsp_if.sv -----
// response channel carrying the outcome of one instruction
interface rvie_rsp_if;
   logic               valid;
   logic               ready;
   rvie_pkg::word_type next_pc;
   logic               overflow;
   logic               syscall_request;
   rvie_pkg::word_type sysc_number;

   modport source (output valid, next_pc, overflow, syscall_request, sysc_number,
                   input ready);
   modport sink   (input valid, next_pc, overflow, syscall_request, sysc_number,
                   output ready);
endinterface

// ----- rtl/register_vm_instruction_execute.sv -----
// top level of the register vm instruction executor
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+----------------------------------------------
//   req_bus  | in  | valid / ready  | kind, first_reg, second_reg, immediate
//   rsp_bus  | out | valid / ready  | next_pc, overflow, syscall_request, sysc_number
//
// one instruction per cycle while responses are not stalled; an accepted request
// reads the register file into the execute stage, then executes into the response register
// the register file sits in a ram with two read ports; the result of the previous
// instruction is forwarded around its write-back
// reset clears the pc and all entry valid bits; entries not yet written
// read as zero
// a stalled response holds the execute stage, and requests are taken while it has room
module register_vm_instruction_execute #(
   parameter int unsigned REG_COUNT  = 255,
   parameter int unsigned FLAG_INDEX = 241
) (
   input  logic        clock,
   input  logic        reset,
   rvie_req_if.sink    req_bus,
   rvie_rsp_if.source  rsp_bus
);

   localparam int unsigned ADDR_W = $clog2(REG_COUNT);
   localparam logic [rvie_pkg::INDEX_W:0] REG_LIMIT = (rvie_pkg::INDEX_W+1)'(REG_COUNT);
   // flag entry may lie beyond the file, then it reads zero and ignores writes
   localparam logic FLAG_OK = (FLAG_INDEX < REG_COUNT);
   localparam logic [ADDR_W-1:0] FLAG_ADDR = ADDR_W'(FLAG_INDEX);

   // handshakes
   logic req_accept;
   logic commit;

   // execute stage
   logic                s1_valid_ff, s1_valid_in;
   rvie_pkg::kind_type  s1_kind_ff;
   rvie_pkg::index_type s1_a_ff, s1_b_ff;
   rvie_pkg::word_type  s1_imm_ff;
   logic                s1_a_rng_ff, s1_b_rng_ff;   // index inside the file
   logic                s1_a_vld_ff, s1_b_vld_ff;   // entry written since reset

   // architectural state
   rvie_pkg::word_type  pc_ff, pc_in;
   logic                flag_nz_ff, flag_nz_in;
   logic [REG_COUNT-1:0] valid_ff, valid_in;

   // last write, forwarded to the following instruction
   logic                fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]   fwd_addr_ff;
   rvie_pkg::word_type  fwd_data_ff;

   // response register
   logic                out_valid_ff, out_valid_in;
   rvie_pkg::word_type  out_next_pc_ff;
   logic                out_overflow_ff;
   logic                out_sysc_req_ff;
   rvie_pkg::word_type  out_sysc_num_ff;

   // ram and operands
   rvie_pkg::word_type  ram_a, ram_b;
   rvie_pkg::word_type  val_a, val_b;
   logic                a_rng_in, b_rng_in;

   // execute results
   logic [rvie_pkg::DATA_W:0] sum;
   rvie_pkg::word_type  addend;
   rvie_pkg::word_type  next_pc;
   logic                overflow;
   logic                sysc_req;
   logic                wr_req;
   logic                wr_ok;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   rvie_pkg::word_type  wr_data;

   // the execute stage frees when its result moves into the response register
   assign commit        = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || commit;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign a_rng_in = ({1'b0, req_bus.first_reg} < REG_LIMIT);
   assign b_rng_in = ({1'b0, req_bus.second_reg} < REG_LIMIT);

   rvie_ram #(
      .WIDTH (rvie_pkg::DATA_W),
      .DEPTH (REG_COUNT)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (req_accept),
      .rd_addr_a (req_bus.first_reg[ADDR_W-1:0]),
      .rd_addr_b (req_bus.second_reg[ADDR_W-1:0]),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   // operand select: out of range reads zero, forwarded write beats the ram,
   // entries never written read zero
   always_comb begin
      if (!s1_a_rng_ff) begin
         val_a = '0;
      end else if (fwd_valid_ff && (fwd_addr_ff == s1_a_ff[ADDR_W-1:0])) begin
         val_a = fwd_data_ff;
      end else if (s1_a_vld_ff) begin
         val_a = ram_a;
      end else begin
         val_a = '0;
      end

      if (!s1_b_rng_ff) begin
         val_b = '0;
      end else if (fwd_valid_ff && (fwd_addr_ff == s1_b_ff[ADDR_W-1:0])) begin
         val_b = fwd_data_ff;
      end else if (s1_b_vld_ff) begin
         val_b = ram_b;
      end else begin
         val_b = '0;
      end
   end

   // execute
   always_comb begin
      addend   = (s1_kind_ff == rvie_pkg::KIND_ADD_REG) ? val_b : s1_imm_ff;
      sum      = {1'b0, val_a} + {1'b0, addend};
      next_pc  = pc_ff + rvie_pkg::LEN_SHORT;
      overflow = 1'b0;
      sysc_req = 1'b0;
      wr_req   = 1'b0;
      wr_ok    = s1_a_rng_ff;
      wr_addr  = s1_a_ff[ADDR_W-1:0];
      wr_data  = '0;

      unique case (s1_kind_ff)
         rvie_pkg::KIND_JMP: begin
            next_pc = s1_imm_ff;
         end
         rvie_pkg::KIND_JE: begin
            next_pc = flag_nz_ff ? s1_imm_ff : pc_ff + rvie_pkg::LEN_REG;
         end
         rvie_pkg::KIND_MOV_REG: begin
            wr_req  = 1'b1;
            wr_data = val_b;
            next_pc = pc_ff + rvie_pkg::LEN_REG;
         end
         rvie_pkg::KIND_MOV_IMM: begin
            wr_req  = 1'b1;
            wr_data = s1_imm_ff;
            next_pc = pc_ff + rvie_pkg::LEN_IMM;
         end
         rvie_pkg::KIND_ADD_REG,
         rvie_pkg::KIND_ADD_IMM: begin
            // a carry out suppresses the write
            overflow = sum[rvie_pkg::DATA_W];
            wr_req   = !sum[rvie_pkg::DATA_W];
            wr_data  = sum[rvie_pkg::DATA_W-1:0];
            next_pc  = pc_ff + ((s1_kind_ff == rvie_pkg::KIND_ADD_REG) ?
                                rvie_pkg::LEN_REG : rvie_pkg::LEN_IMM);
         end
         rvie_pkg::KIND_CMP_REG: begin
            wr_req  = 1'b1;
            wr_ok   = FLAG_OK;
            wr_addr = FLAG_ADDR;
            wr_data = {{(rvie_pkg::DATA_W-1){1'b0}}, (val_a == val_b)};
            next_pc = pc_ff + rvie_pkg::LEN_REG;
         end
         rvie_pkg::KIND_CMP_IMM: begin
            wr_req  = 1'b1;
            wr_ok   = FLAG_OK;
            wr_addr = FLAG_ADDR;
            wr_data = {{(rvie_pkg::DATA_W-1){1'b0}}, (val_a == s1_imm_ff)};
            next_pc = pc_ff + rvie_pkg::LEN_IMM;
         end
         rvie_pkg::KIND_SYSC: begin
            sysc_req = 1'b1;
            next_pc  = pc_ff + rvie_pkg::LEN_REG;
         end
         default: begin
            // nop and unused codes advance by one
            next_pc = pc_ff + rvie_pkg::LEN_SHORT;
         end
      endcase

      wr_en = commit && wr_req && wr_ok;
   end

   // next state of control
   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (commit ? 1'b0 : s1_valid_ff);
      out_valid_in = commit ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
      pc_in        = commit ? next_pc : pc_ff;
      fwd_valid_in = fwd_valid_ff || wr_en;
      valid_in     = valid_ff;
      flag_nz_in   = flag_nz_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
         if (wr_addr == FLAG_ADDR) begin
            flag_nz_in = FLAG_OK && (wr_data != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= '0;
         fwd_valid_ff <= 1'b0;
         valid_ff     <= '0;
         flag_nz_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         pc_ff        <= pc_in;
         fwd_valid_ff <= fwd_valid_in;
         valid_ff     <= valid_in;
         flag_nz_ff   <= flag_nz_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff  <= rvie_pkg::kind_type'(req_bus.kind);
         s1_a_ff     <= req_bus.first_reg;
         s1_b_ff     <= req_bus.second_reg;
         s1_imm_ff   <= req_bus.immediate;
         s1_a_rng_ff <= a_rng_in;
         s1_b_rng_ff <= b_rng_in;
         // a write on this same edge is covered by the forward path
         s1_a_vld_ff <= a_rng_in && valid_ff[req_bus.first_reg[ADDR_W-1:0]];
         s1_b_vld_ff <= b_rng_in && valid_ff[req_bus.second_reg[ADDR_W-1:0]];
      end
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
      if (commit) begin
         out_next_pc_ff  <= next_pc;
         out_overflow_ff <= overflow;
         out_sysc_req_ff <= sysc_req;
         out_sysc_num_ff <= sysc_req ? s1_imm_ff : '0;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.next_pc         = out_next_pc_ff;
   assign rsp_bus.overflow        = out_overflow_ff;
   assign rsp_bus.syscall_request = out_sysc_req_ff;
   assign rsp_bus.sysc_number     = out_sysc_num_ff;

endmodule

// ----- rtl/rvie_ram.sv -----
// generic ram, one write port and two registered read ports
module rvie_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // read during write returns the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- rtl/rvie_checker.sv -----
// port-level checker of the instruction executor and its bind
module rvie_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_overflow,
   input logic               rsp_syscall_request,
   input rvie_pkg::word_type rsp_sysc_number
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no response right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

   // a syscall never comes with an add overflow, and the number is zero otherwise
   a_rsp_sysc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflow && rsp_syscall_request) &&
                    (rsp_syscall_request || (rsp_sysc_number == '0)))
      else $error("syscall fields inconsistent");

   // a request taken with the response stage empty and free shows through the execute stage and the response register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid && rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("response missing after request");

endmodule

bind register_vm_instruction_execute rvie_checker u_rvie_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_overflow        (rsp_bus.overflow),
   .rsp_syscall_request (rsp_bus.syscall_request),
   .rsp_sysc_number     (rsp_bus.sysc_number)
);
